/* hdl/ljpd_pkg.sv */
// ----------------------------------------------------------------------------
// ljpd_pkg
// Shared constants and types for the lossless JPEG predictor decoder.
// ----------------------------------------------------------------------------
package ljpd_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int WIDTH_W   = 11;
  localparam int HEIGHT_W  = 16;
  localparam int PIX_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;
  // Column arithmetic wide enough for both the line length and the width register
  localparam int COL_W     = (ADDR_W + 1 > WIDTH_W) ? ADDR_W + 1 : WIDTH_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PREDICTOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 2'd2;

  // Predictor modes
  localparam logic [2:0] PRED_ZERO  = 3'd0;
  localparam logic [2:0] PRED_B     = 3'd1;
  localparam logic [2:0] PRED_A     = 3'd2;
  localparam logic [2:0] PRED_C     = 3'd3;
  localparam logic [2:0] PRED_PLANE = 3'd4;
  localparam logic [2:0] PRED_A_HBC = 3'd5;
  localparam logic [2:0] PRED_B_HAC = 3'd6;
  localparam logic [2:0] PRED_AVG   = 3'd7;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(1024);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(1);

  // Per-pixel context worked out when a transaction is accepted
  typedef struct packed {
    logic [2:0]        mode;
    logic [ADDR_W-1:0] addr;
    logic              top;
    logic              first_col;
    logic              row_end;
    logic              image_end;
  } pix_ctx_t;

endpackage

/* hdl/lossless_jpeg_predictor_decoder_unit.sv */
// ----------------------------------------------------------------------------
// lossless_jpeg_predictor_decoder_unit
// Rebuilds 8-bit pixels from residual bytes in raster order using the
// selected lossless JPEG predictor.
// ----------------------------------------------------------------------------
// The unit takes one residual per cycle and returns one pixel per cycle
// while out_ready is high; a residual passes the stage register, then the
// output register. The pixel above is read from a line buffer RAM (one
// read, one write per cycle) when the residual is accepted; the next stage
// forms the prediction and sum, writes the pixel back, and feeds the left
// neighbour straight back into the following pixel. The line buffer is not
// cleared after reset: every entry that a later row reads is written on the
// first row. Write the configuration registers only between transactions;
// a change takes effect on the next residual. A column past a new width
// closes the row on that residual; a row past a new height ends the image.
module lossless_jpeg_predictor_decoder_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           config_write,
  input  logic [ljpd_pkg::CFG_IDX_W-1:0] config_index,
  input  logic [ljpd_pkg::CFG_W-1:0]     config_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ljpd_pkg::PIX_W-1:0]     residual,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ljpd_pkg::PIX_W-1:0]     pixel,
  output logic                           row_end,
  output logic                           image_end
);

  ljpd_pkg::pix_ctx_t               ctx;
  logic                             accept;
  logic                             wr_en;
  logic [ljpd_pkg::ADDR_W-1:0]      wr_addr;
  logic [ljpd_pkg::PIX_W-1:0]       wr_data;
  logic [ljpd_pkg::PIX_W-1:0]       rd_data;

  ljpd_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .config_write (config_write),
    .config_index (config_index),
    .config_data  (config_data),
    .accept       (accept),
    .ctx          (ctx)
  );

  ljpd_line_ram #(
    .DEPTH (ljpd_pkg::MAX_WIDTH),
    .WIDTH (ljpd_pkg::PIX_W)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (ctx.addr),
    .rd_data (rd_data)
  );

  ljpd_recon u_recon (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .residual  (residual),
    .ctx       (ctx),
    .accept    (accept),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_data   (rd_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel     (pixel),
    .row_end   (row_end),
    .image_end (image_end)
  );

endmodule

/* hdl/ljpd_line_ram.sv */
// ----------------------------------------------------------------------------
// ljpd_line_ram
// Simple dual-port line buffer: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ljpd_line_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read-first: a read at the written address returns the old contents
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/ljpd_ctrl.sv */
// ----------------------------------------------------------------------------
// ljpd_ctrl
// Configuration registers and raster position counters.
// ----------------------------------------------------------------------------
module ljpd_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           config_write,
  input  logic [ljpd_pkg::CFG_IDX_W-1:0] config_index,
  input  logic [ljpd_pkg::CFG_W-1:0]     config_data,
  input  logic                           accept,
  output ljpd_pkg::pix_ctx_t             ctx
);

  logic [2:0]                        predictor_select;
  logic [ljpd_pkg::WIDTH_W-1:0]      image_width;
  logic [ljpd_pkg::HEIGHT_W-1:0]     image_height;
  logic [ljpd_pkg::ADDR_W-1:0]       column_count;
  logic [ljpd_pkg::HEIGHT_W-1:0]     row_count;

  logic [ljpd_pkg::COL_W-1:0]        eff_width;
  logic [ljpd_pkg::HEIGHT_W:0]       eff_height;
  logic [ljpd_pkg::COL_W-1:0]        col_inc;
  logic [ljpd_pkg::HEIGHT_W:0]       row_inc;
  logic                              row_end;
  logic                              image_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      predictor_select <= ljpd_pkg::PRED_ZERO;
      image_width      <= ljpd_pkg::WIDTH_RESET;
      image_height     <= ljpd_pkg::HEIGHT_RESET;
    end else if (config_write) begin
      unique case (config_index)
        ljpd_pkg::CFG_PREDICTOR: predictor_select <= config_data[2:0];
        ljpd_pkg::CFG_WIDTH:     image_width      <= config_data[ljpd_pkg::WIDTH_W-1:0];
        ljpd_pkg::CFG_HEIGHT:    image_height     <= config_data[ljpd_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp width into 1..MAX_WIDTH, height zero counts as one
  always_comb begin
    eff_width = ljpd_pkg::COL_W'(image_width);
    if (image_width == '0) begin
      eff_width = ljpd_pkg::COL_W'(1);
    end else if (eff_width > ljpd_pkg::COL_W'(ljpd_pkg::MAX_WIDTH)) begin
      eff_width = ljpd_pkg::COL_W'(ljpd_pkg::MAX_WIDTH);
    end
    eff_height = (image_height == '0) ? (ljpd_pkg::HEIGHT_W+1)'(1)
                                      : {1'b0, image_height};
  end

  assign col_inc   = ljpd_pkg::COL_W'(column_count) + ljpd_pkg::COL_W'(1);
  assign row_inc   = {1'b0, row_count} + (ljpd_pkg::HEIGHT_W+1)'(1);
  assign row_end   = col_inc >= eff_width;
  assign image_end = row_end && (row_inc >= eff_height);

  always_comb begin
    ctx.mode      = predictor_select;
    ctx.addr      = column_count;
    ctx.top       = (row_count == '0);
    ctx.first_col = (column_count == '0);
    ctx.row_end   = row_end;
    ctx.image_end = image_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (row_end) begin
        column_count <= '0;
        row_count    <= image_end ? '0 : row_inc[ljpd_pkg::HEIGHT_W-1:0];
      end else begin
        column_count <= col_inc[ljpd_pkg::ADDR_W-1:0];
      end
    end
  end

endmodule

/* hdl/ljpd_recon.sv */
// ----------------------------------------------------------------------------
// ljpd_recon
// Reconstruction stage: prediction, pixel sum, line buffer write-back and
// output register.
// ----------------------------------------------------------------------------
module ljpd_recon (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ljpd_pkg::PIX_W-1:0]    residual,
  input  ljpd_pkg::pix_ctx_t            ctx,
  output logic                          accept,
  output logic                          wr_en,
  output logic [ljpd_pkg::ADDR_W-1:0]   wr_addr,
  output logic [ljpd_pkg::PIX_W-1:0]    wr_data,
  input  logic [ljpd_pkg::PIX_W-1:0]    rd_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ljpd_pkg::PIX_W-1:0]    pixel,
  output logic                          row_end,
  output logic                          image_end
);

  logic                       s1_valid;
  ljpd_pkg::pix_ctx_t         s1;
  logic [ljpd_pkg::PIX_W-1:0] s1_residual;
  logic                       fwd;
  logic [ljpd_pkg::PIX_W-1:0] fwd_data;
  logic [ljpd_pkg::PIX_W-1:0] left_pixel;
  logic [ljpd_pkg::PIX_W-1:0] upper_left_pixel;
  logic [ljpd_pkg::PIX_W-1:0] above;
  logic [ljpd_pkg::PIX_W-1:0] pred;
  logic [ljpd_pkg::PIX_W-1:0] sum;
  logic                       commit;

  function automatic logic [7:0] predict(input logic [2:0] mode, input logic [7:0] a,
                                         input logic [7:0] b, input logic [7:0] c,
                                         input logic top, input logic first_col);
    logic signed [9:0] sa;
    logic signed [9:0] sb;
    logic signed [9:0] sc;
    logic signed [9:0] d;
    logic signed [9:0] t;
    logic signed [9:0] p;
    sa = $signed({2'b00, a});
    sb = $signed({2'b00, b});
    sc = $signed({2'b00, c});
    p  = '0;
    if (mode == ljpd_pkg::PRED_ZERO || (top && first_col)) begin
      p = '0;
    end else if (mode == ljpd_pkg::PRED_B) begin
      p = top ? sa : sb;
    end else if (mode == ljpd_pkg::PRED_A) begin
      p = first_col ? sb : sa;
    end else if (first_col) begin
      p = sb;
    end else if (top) begin
      p = sa;
    end else begin
      case (mode)
        ljpd_pkg::PRED_C:     p = sc;
        ljpd_pkg::PRED_PLANE: p = sa + sb - sc;
        ljpd_pkg::PRED_A_HBC, ljpd_pkg::PRED_B_HAC: begin
          d = (mode == ljpd_pkg::PRED_A_HBC) ? sb - sc : sa - sc;
          // halve toward zero: bias negatives by one before the shift
          t = d + $signed({9'b0, d[9]});
          p = ((mode == ljpd_pkg::PRED_A_HBC) ? sa : sb) + (t >>> 1);
        end
        default:              p = (sa + sb) >>> 1;
      endcase
    end
    return p[7:0];
  endfunction

  assign commit   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || commit;
  assign accept   = in_valid && in_ready;

  // Same-entry read and write in one cycle: take the value being written
  assign above = fwd ? fwd_data : rd_data;
  assign pred  = predict(s1.mode, left_pixel, above, upper_left_pixel, s1.top, s1.first_col);
  assign sum   = s1_residual + pred;

  assign wr_en   = commit;
  assign wr_addr = s1.addr;
  assign wr_data = sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (commit) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (accept) begin
      fwd <= commit && (s1.addr == ctx.addr);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1          <= ctx;
      s1_residual <= residual;
      fwd_data    <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_pixel       <= '0;
      upper_left_pixel <= '0;
    end else if (commit) begin
      left_pixel       <= sum;
      upper_left_pixel <= above;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      pixel     <= sum;
      row_end   <= s1.row_end;
      image_end <= s1.image_end;
    end
  end

  a_fwd_set: assert property (@(posedge clk) disable iff (rst)
    accept && commit && (s1.addr == ctx.addr) |=> fwd)
    else $error("forwarding flag missed on same-entry overlap");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !commit |=> s1_valid && $stable(s1) && $stable(s1_residual))
    else $error("stalled stage lost its transaction");

  a_first_col: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1.first_col |-> s1.addr == '0)
    else $error("first column flag with non-zero address");

  a_end_flags: assert property (@(posedge clk) disable iff (rst)
    commit && s1.image_end |-> s1.row_end)
    else $error("image end without row end");

endmodule
